### sv/sci_pkg.sv
// Shared constants for the segment and circle intersection block.
package sci_pkg;

	// Default width of one signed coordinate
	localparam int COORD_WIDTH = 24;

	// Tolerance register
	localparam int TOL_WIDTH = 8;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

	// A coordinate difference saturates to this many bits
	localparam int DIFF_CAP = 32;

endpackage

### sv/sci_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module sci_sqrt #(
	parameter int IN_W   = 50,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [IN_W-1:0]        rad,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_vld,
	output logic [(IN_W+1)/2-1:0]  root,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int RW = (IN_W + 1) / 2;
	localparam int PW = 2 * RW;

	logic [PW-1:0]     rad_s  [RW-1];
	logic [RW-1:0]     rem_s  [RW-1];
	logic [RW-1:0]     root_s [RW];
	logic [SIDE_W-1:0] side_s [RW];
	logic              vld_s  [RW];

	for (genvar g = 0; g < RW; g++) begin : gen_stage
		logic [PW-1:0]     rad_i;
		logic [RW-1:0]     rem_i;
		logic [RW-1:0]     root_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		logic [RW+1:0]     cur;
		logic [RW+1:0]     trial;
		logic [RW+1:0]     dif;
		logic              take;

		if (g == 0) begin : gen_first
			assign rad_i  = PW'(rad);
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
			assign vld_i  = in_vld;
		end else begin : gen_next
			assign rad_i  = rad_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign side_i = side_s[g-1];
			assign vld_i  = vld_s[g-1];
		end

		// Bring down the next bit pair and try root*4+1
		assign cur   = {rem_i, rad_i[PW-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign take  = (cur >= trial);
		assign dif   = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g] <= {root_i[RW-2:0], take};
				side_s[g] <= side_i;
			end
		end

		if (g < RW - 1) begin : gen_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[g] <= rad_i << 2;
					rem_s[g] <= take ? dif[RW-1:0] : cur[RW-1:0];
				end
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule

### sv/sci_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module sci_div #(
	parameter int N_W    = 50,
	parameter int D_W    = 25,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [N_W-1:0]    num,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [N_W-1:0]    quo,
	output logic [D_W-1:0]    den_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [N_W-1:0]    num_s  [N_W-1];
	logic [D_W-1:0]    rem_s  [N_W-1];
	logic [N_W-1:0]    quo_s  [N_W];
	logic [D_W-1:0]    den_s  [N_W];
	logic [SIDE_W-1:0] side_s [N_W];
	logic              vld_s  [N_W];

	for (genvar g = 0; g < N_W; g++) begin : gen_stage
		logic [N_W-1:0]    num_i;
		logic [D_W-1:0]    rem_i;
		logic [N_W-1:0]    quo_i;
		logic [D_W-1:0]    den_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		logic [D_W:0]      cur;
		logic [D_W:0]      dif;
		logic              take;

		if (g == 0) begin : gen_first
			assign num_i  = num;
			assign rem_i  = '0;
			assign quo_i  = '0;
			assign den_i  = den;
			assign side_i = side_in;
			assign vld_i  = in_vld;
		end else begin : gen_next
			assign num_i  = num_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign quo_i  = quo_s[g-1];
			assign den_i  = den_s[g-1];
			assign side_i = side_s[g-1];
			assign vld_i  = vld_s[g-1];
		end

		// Shift in the next numerator bit and try to subtract the divisor
		assign cur  = {rem_i, num_i[N_W-1]};
		assign take = (cur >= {1'b0, den_i});
		assign dif  = cur - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g]  <= {quo_i[N_W-2:0], take};
				den_s[g]  <= den_i;
				side_s[g] <= side_i;
			end
		end

		if (g < N_W - 1) begin : gen_carry
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[g] <= num_i << 1;
					rem_s[g] <= take ? dif[D_W-1:0] : cur[D_W-1:0];
				end
			end
		end
	end

	assign out_vld  = vld_s[N_W-1];
	assign quo      = quo_s[N_W-1];
	assign den_out  = den_s[N_W-1];
	assign side_out = side_s[N_W-1];

endmodule

### sv/segment_circle_intersection.sv
// Top level: fully pipelined segment and circle intersection.
//
// Use: a query carries a segment (start_x/y, end_x/y), a circle center
// (center_x/y) and a radius, all fixed point with one common LSB. The query
// is taken at a clock edge where query_valid is high and query_stall low.
// One result request leaves per query, in order, on result_valid; it is
// taken where result_valid is high and result_stall low.
// Throughput: one query per cycle unless a refused result stalls the pipeline.
// The pipeline depth comes from the two bit-per-stage square roots (segment
// length, then the discriminant root) and the bit-per-stage dividers for the
// projection and the point coordinates.
// A stalled result holds the whole pipeline: query_stall rises for as long
// as a finished result waits, and nothing is lost or repeated.
// The tolerance register is written on cfg_valid/cfg_ready (always ready);
// write it only while no query is in flight.
// Reset clears all valid bits and loads a tolerance of one LSB.
module segment_circle_intersection #(
	parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Query channel
	input  logic                                query_valid,
	output logic                                query_stall,
	input  logic signed [COORD_WIDTH-1:0]       start_x,
	input  logic signed [COORD_WIDTH-1:0]       start_y,
	input  logic signed [COORD_WIDTH-1:0]       end_x,
	input  logic signed [COORD_WIDTH-1:0]       end_y,
	input  logic signed [COORD_WIDTH-1:0]       center_x,
	input  logic signed [COORD_WIDTH-1:0]       center_y,
	input  logic        [COORD_WIDTH-2:0]       radius,
	// Tolerance register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [sci_pkg::TOL_WIDTH-1:0] cfg_data,
	// Result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                hit,
	output logic                                first_valid,
	output logic signed [COORD_WIDTH-1:0]       first_x,
	output logic signed [COORD_WIDTH-1:0]       first_y,
	output logic                                second_valid,
	output logic signed [COORD_WIDTH-1:0]       second_x,
	output logic signed [COORD_WIDTH-1:0]       second_y,
	output logic                                degenerate
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = (CW + 1 > sci_pkg::DIFF_CAP) ? sci_pkg::DIFF_CAP : CW + 1;
	localparam int PW   = 2 * DW + 1;   // signed projection numerator
	localparam int PMW  = 2 * DW;       // its magnitude
	localparam int QW   = 2 * DW;       // squared lengths
	localparam int R2W  = 2 * (CW - 1);
	localparam int SW   = 2 * DW + 1;   // discriminant
	localparam int FW   = DW + 1;       // root of the discriminant
	localparam int AW   = DW + 1;       // signed projection
	localparam int TW   = DW + 3;       // line parameter t
	localparam int PRW  = TW + DW;      // t times a direction component
	localparam int MW   = PRW - 1;
	localparam int XW   = TW + 1;       // point before saturation
	localparam int TOLW = sci_pkg::TOL_WIDTH;

	localparam logic signed [CW:0]   DMAX = (CW+1)'((longint'(1) << (DW - 1)) - longint'(1));
	localparam logic signed [CW:0]   DMIN = -DMAX;
	localparam logic signed [XW-1:0] OMAX = XW'((longint'(1) << (CW - 1)) - longint'(1));
	localparam logic signed [XW-1:0] OMIN = ~OMAX;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic                 deg;
	} geo_t;

	typedef struct packed {
		logic signed [PW-1:0] p;
		logic [QW-1:0]        e2;
		logic [R2W-1:0]       r2;
		geo_t                 geo;
	} side1_t;

	typedef struct packed {
		logic           pneg;
		logic [QW-1:0]  e2;
		logic [R2W-1:0] r2;
		geo_t           geo;
	} side2_t;

	typedef struct packed {
		logic signed [AW-1:0] a;
		logic [DW-1:0]        len;
		logic                 neg;
		geo_t                 geo;
	} side3_t;

	typedef struct packed {
		logic                 acc0;
		logic                 acc1;
		logic                 neg;
		logic                 deg;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic                 sgn;
	} side4_t;

	function automatic logic signed [DW-1:0] sat_diff(input logic signed [CW:0] v);
		logic signed [CW:0] c;
		c = v;
		if (v > DMAX) begin
			c = DMAX;
		end else if (v < DMIN) begin
			c = DMIN;
		end
		return c[DW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] sat_out(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] c;
		c = v;
		if (v > OMAX) begin
			c = OMAX;
		end else if (v < OMIN) begin
			c = OMIN;
		end
		return c[CW-1:0];
	endfunction

	// Global advance: hold everything while a finished result is refused
	logic adv;
	assign adv         = ~(result_valid & result_stall);
	assign query_stall = ~adv;

	// Tolerance register
	logic [TOLW-1:0] tol_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= sci_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// Stage 1: differences against the start point, saturated
	logic signed [CW:0] ddx, ddy, dqx, dqy;
	assign ddx = (CW+1)'(end_x) - (CW+1)'(start_x);
	assign ddy = (CW+1)'(end_y) - (CW+1)'(start_y);
	assign dqx = (CW+1)'(center_x) - (CW+1)'(start_x);
	assign dqy = (CW+1)'(center_y) - (CW+1)'(start_y);

	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, qx_s1, qy_s1;
	logic signed [CW-1:0] sx_s1, sy_s1;
	logic [CW-2:0]        r_s1;
	logic                 deg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= sat_diff(ddx);
			dy_s1  <= sat_diff(ddy);
			qx_s1  <= sat_diff(dqx);
			qy_s1  <= sat_diff(dqy);
			sx_s1  <= start_x;
			sy_s1  <= start_y;
			r_s1   <= radius;
			// A zero-length segment has both differences zero
			deg_s1 <= (ddx == '0) && (ddy == '0);
		end
	end

	// Stage 2: all squares and cross products
	logic                 vld_s2;
	logic signed [QW-1:0] dxx_s2, dyy_s2, pxx_s2, pyy_s2, exx_s2, eyy_s2;
	logic [R2W-1:0]       r2_s2;
	geo_t                 geo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			pxx_s2 <= qx_s1 * dx_s1;
			pyy_s2 <= qy_s1 * dy_s1;
			exx_s2 <= qx_s1 * qx_s1;
			eyy_s2 <= qy_s1 * qy_s1;
			r2_s2  <= R2W'(r_s1) * R2W'(r_s1);
			geo_s2 <= '{dx: dx_s1, dy: dy_s1, sx: sx_s1, sy: sy_s1, deg: deg_s1};
		end
	end

	// Stage 3: sums of products
	logic                 vld_s3;
	logic [QW-1:0]        l2_s3, e2_s3;
	logic signed [PW-1:0] p_s3;
	logic [R2W-1:0]       r2_s3;
	geo_t                 geo_s3;
	logic signed [QW-1:0] l2_sum, e2_sum;

	assign l2_sum = dxx_s2 + dyy_s2;
	assign e2_sum = exx_s2 + eyy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s3  <= l2_sum;
			e2_s3  <= e2_sum;
			p_s3   <= PW'(pxx_s2) + PW'(pyy_s2);
			r2_s3  <= r2_s2;
			geo_s3 <= geo_s2;
		end
	end

	// Segment length L = isqrt(D.D)
	side1_t        side1_in, side1_out;
	logic          sq1_vld;
	logic [DW-1:0] len_root;

	assign side1_in = '{p: p_s3, e2: e2_s3, r2: r2_s3, geo: geo_s3};

	sci_sqrt #(
		.IN_W   (QW),
		.SIDE_W ($bits(side1_t))
	) u_sqrt_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s3),
		.rad      (l2_s3),
		.side_in  (side1_in),
		.out_vld  (sq1_vld),
		.root     (len_root),
		.side_out (side1_out)
	);

	// Stage 4: magnitude of the projection numerator
	logic                 vld_s4;
	logic [DW-1:0]        len_s4;
	logic [PMW-1:0]       pmag_s4;
	side2_t               side2_s4;
	logic signed [PW-1:0] pabs;

	assign pabs = side1_out.p[PW-1] ? -side1_out.p : side1_out.p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= sq1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s4   <= len_root;
			pmag_s4  <= pabs[PMW-1:0];
			side2_s4 <= '{pneg: side1_out.p[PW-1], e2: side1_out.e2, r2: side1_out.r2,
				geo: side1_out.geo};
		end
	end

	// Projection a = (E.D) / L, truncated toward zero
	logic           dv1_vld;
	logic [PMW-1:0] a_quo;
	logic [DW-1:0]  len_dv1;
	side2_t         side2_out;

	sci_div #(
		.N_W    (PMW),
		.D_W    (DW),
		.SIDE_W ($bits(side2_t))
	) u_div_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.num      (pmag_s4),
		.den      (len_s4),
		.side_in  (side2_s4),
		.out_vld  (dv1_vld),
		.quo      (a_quo),
		.den_out  (len_dv1),
		.side_out (side2_out)
	);

	// Stage 5: a squared and signed a
	logic                 vld_s5;
	logic [QW-1:0]        a2_s5;
	logic signed [AW-1:0] a_s5;
	logic [DW-1:0]        len_s5;
	logic [QW-1:0]        e2_s5;
	logic [R2W-1:0]       r2_s5;
	geo_t                 geo_s5;
	logic [DW-1:0]        amag;
	logic signed [AW-1:0] apos;

	assign amag = a_quo[DW-1:0];
	assign apos = $signed({1'b0, amag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= dv1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a2_s5  <= QW'(amag) * QW'(amag);
			a_s5   <= side2_out.pneg ? -apos : apos;
			len_s5 <= len_dv1;
			e2_s5  <= side2_out.e2;
			r2_s5  <= side2_out.r2;
			geo_s5 <= side2_out.geo;
		end
	end

	// Stage 6: r^2 + a^2
	logic                 vld_s6;
	logic [SW-1:0]        sum_s6;
	logic signed [AW-1:0] a_s6;
	logic [DW-1:0]        len_s6;
	logic [QW-1:0]        e2_s6;
	geo_t                 geo_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s6 <= SW'(a2_s5) + SW'(r2_s5);
			a_s6   <= a_s5;
			len_s6 <= len_s5;
			e2_s6  <= e2_s5;
			geo_s6 <= geo_s5;
		end
	end

	// Stage 7: discriminant, the borrow flags a miss
	logic          vld_s7;
	logic [SW-1:0] disc_s7;
	side3_t        side3_s7;
	logic [SW:0]   disc_full;

	assign disc_full = {1'b0, sum_s6} - {1'b0, SW'(e2_s6)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s7  <= disc_full[SW-1:0];
			side3_s7 <= '{a: a_s6, len: len_s6, neg: disc_full[SW], geo: geo_s6};
		end
	end

	// f = isqrt(discriminant)
	logic          sq2_vld;
	logic [FW-1:0] f_root;
	side3_t        side3_out;

	sci_sqrt #(
		.IN_W   (SW),
		.SIDE_W ($bits(side3_t))
	) u_sqrt_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s7),
		.rad      (disc_s7),
		.side_in  (side3_s7),
		.out_vld  (sq2_vld),
		.root     (f_root),
		.side_out (side3_out)
	);

	// Stage 8: both line parameters
	logic                 vld_s8;
	logic signed [TW-1:0] t0_s8, t1_s8;
	side3_t               side3_s8;
	logic signed [TW-1:0] fext;

	assign fext = TW'($signed({1'b0, f_root}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= sq2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s8    <= TW'(side3_out.a) - fext;
			t1_s8    <= TW'(side3_out.a) + fext;
			side3_s8 <= side3_out;
		end
	end

	// Stage 9: range test against [-tol, L + tol], and t times D
	logic                  vld_s9;
	logic                  acc0_s9, acc1_s9;
	logic signed [PRW-1:0] m_s9 [4];
	side3_t                side3_s9;
	logic signed [TW-1:0]  tol_ext, lo_lim, hi_lim;

	assign tol_ext = TW'($signed({1'b0, tol_q}));
	assign lo_lim  = -tol_ext;
	assign hi_lim  = TW'($signed({1'b0, side3_s8.len})) + tol_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc0_s9  <= (t0_s8 >= lo_lim) && (t0_s8 <= hi_lim);
			acc1_s9  <= (t1_s8 >= lo_lim) && (t1_s8 <= hi_lim);
			m_s9[0]  <= t0_s8 * side3_s8.geo.dx;
			m_s9[1]  <= t0_s8 * side3_s8.geo.dy;
			m_s9[2]  <= t1_s8 * side3_s8.geo.dx;
			m_s9[3]  <= t1_s8 * side3_s8.geo.dy;
			side3_s9 <= side3_s8;
		end
	end

	// Stage 10: product magnitudes and signs
	logic                  vld_s10;
	logic [MW-1:0]         mag_s10 [4];
	logic                  sgn_s10 [4];
	logic [DW-1:0]         len_s10;
	side4_t                side4_s10;
	logic signed [PRW-1:0] mabs [4];

	for (genvar k = 0; k < 4; k++) begin : gen_abs
		assign mabs[k] = m_s9[k][PRW-1] ? -m_s9[k] : m_s9[k];

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s10[k] <= mabs[k][MW-1:0];
				sgn_s10[k] <= m_s9[k][PRW-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s10   <= side3_s9.len;
			side4_s10 <= '{acc0: acc0_s9, acc1: acc1_s9, neg: side3_s9.neg,
				deg: side3_s9.geo.deg, sx: side3_s9.geo.sx, sy: side3_s9.geo.sy,
				sgn: m_s9[0][PRW-1]};
		end
	end

	// Point offsets t*D/L, four dividers in lockstep
	logic          dv_vld;
	logic [MW-1:0] q_dv [4];
	side4_t        side4_out;
	logic          sgn_dv [1:3];

	sci_div #(
		.N_W    (MW),
		.D_W    (DW),
		.SIDE_W ($bits(side4_t))
	) u_div_fx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s10),
		.num      (mag_s10[0]),
		.den      (len_s10),
		.side_in  (side4_s10),
		.out_vld  (dv_vld),
		.quo      (q_dv[0]),
		.den_out  (),
		.side_out (side4_out)
	);

	for (genvar k = 1; k < 4; k++) begin : gen_div
		sci_div #(
			.N_W    (MW),
			.D_W    (DW),
			.SIDE_W (1)
		) u_div_pt (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (vld_s10),
			.num      (mag_s10[k]),
			.den      (len_s10),
			.side_in  (sgn_s10[k]),
			.out_vld  (),
			.quo      (q_dv[k]),
			.den_out  (),
			.side_out (sgn_dv[k])
		);
	end

	// Stage 11: restore the sign of each offset
	logic                 vld_s11;
	logic signed [TW-1:0] qs_s11 [4];
	side4_t               side4_s11;
	logic                 q_neg [4];
	logic signed [TW-1:0] qpos [4];

	assign q_neg[0] = side4_out.sgn;
	assign q_neg[1] = sgn_dv[1];
	assign q_neg[2] = sgn_dv[2];
	assign q_neg[3] = sgn_dv[3];

	for (genvar k = 0; k < 4; k++) begin : gen_sign
		assign qpos[k] = $signed({1'b0, q_dv[k][TW-2:0]});

		always_ff @(posedge clk) begin
			if (adv) begin
				qs_s11[k] <= q_neg[k] ? -qpos[k] : qpos[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s11 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side4_s11 <= side4_out;
		end
	end

	// Output register: add the start point, saturate, drop invalid points
	logic                 res_vld_q;
	logic                 hit_q, fv_q, sv_q, deg_q;
	logic signed [CW-1:0] fx_q, fy_q, sx_q, sy_q;
	logic                 ok0, ok1;
	logic signed [XW-1:0] pt [4];

	assign ok0   = side4_s11.acc0 & ~side4_s11.neg & ~side4_s11.deg;
	assign ok1   = side4_s11.acc1 & ~side4_s11.neg & ~side4_s11.deg;
	assign pt[0] = XW'(side4_s11.sx) + XW'(qs_s11[0]);
	assign pt[1] = XW'(side4_s11.sy) + XW'(qs_s11[1]);
	assign pt[2] = XW'(side4_s11.sx) + XW'(qs_s11[2]);
	assign pt[3] = XW'(side4_s11.sy) + XW'(qs_s11[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= ok0 | ok1;
			fv_q  <= ok0;
			sv_q  <= ok1;
			deg_q <= side4_s11.deg;
			fx_q  <= ok0 ? sat_out(pt[0]) : '0;
			fy_q  <= ok0 ? sat_out(pt[1]) : '0;
			sx_q  <= ok1 ? sat_out(pt[2]) : '0;
			sy_q  <= ok1 ? sat_out(pt[3]) : '0;
		end
	end

	assign result_valid = res_vld_q;
	assign hit          = hit_q;
	assign first_valid  = fv_q;
	assign first_x      = fx_q;
	assign first_y      = fy_q;
	assign second_valid = sv_q;
	assign second_x     = sx_q;
	assign second_y     = sy_q;
	assign degenerate   = deg_q;

	// A zero-length segment never reports a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> !hit && !first_valid && !second_valid)
		else $error("degenerate segment reported a hit");

	// hit is exactly the OR of the two point flags
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (hit == (first_valid | second_valid)))
		else $error("hit disagrees with point flags");

	// Invalid points read as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !first_valid |-> (first_x == '0) && (first_y == '0))
		else $error("invalid first point not cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !second_valid |-> (second_x == '0) && (second_y == '0))
		else $error("invalid second point not cleared");

endmodule
